[sv/adsr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adsr_pkg - shared types, constants and curve table for the ADSR envelope
// Holds the sequencer states, the stage codes, register indexes and the
// elaboration-time builder for the exponential curve table.
// ---------------------------------------------------------------------------
package adsr_pkg;

  // Default phase fraction width, table size and fixed field widths
  localparam int PHASE_FRAC_BITS_DEF = 24;
  localparam int CURVE_LOG2          = 8;
  localparam int CURVE_DEPTH         = 1 << CURVE_LOG2;
  localparam int CURVE_AW            = CURVE_LOG2 + 1;
  localparam int TIME_W              = 16;
  localparam int LEVEL_W             = 17;
  localparam int OFF_W               = 17;
  localparam int SCALE_W             = 4;
  localparam int RATE_W              = 18;
  localparam int PROD_W              = TIME_W + SCALE_W;
  localparam int DEN_W               = PROD_W + RATE_W;
  localparam int CFG_IDX_W           = 3;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(65536);
  localparam logic [TIME_W-1:0]  TIME_MAX   = TIME_W'(65535);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 3'd5;

  typedef enum logic [1:0] {
    STG_ATTACK  = 2'd0,
    STG_DECAY   = 2'd1,
    STG_SUSTAIN = 2'd2,
    STG_RELEASE = 2'd3
  } stage_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_DEN,
    ST_CHK,
    ST_DIV,
    ST_PHASE,
    ST_RD_A,
    ST_RD_B,
    ST_INTERP,
    ST_MUL0,
    ST_MUL1,
    ST_OUT
  } state_t;

  typedef logic [LEVEL_W-1:0] curve_t [CURVE_DEPTH+1];

  // Add a signed offset to a base and clamp to 0..top
  function automatic logic [LEVEL_W-1:0] sat_sum(input logic [LEVEL_W-1:0] base,
                                                 input logic signed [OFF_W-1:0] off,
                                                 input logic [LEVEL_W-1:0] top);
    logic signed [LEVEL_W+1:0] s;
    s = $signed({2'b00, base}) + (LEVEL_W+2)'(off);
    if (s < 0) return '0;
    if (s > $signed({2'b00, top})) return top;
    return s[LEVEL_W-1:0];
  endfunction

  // Q0.32 power by squaring with truncation
  function automatic longint unsigned q32_pow(input longint unsigned base_in,
                                              input int n_in);
    longint unsigned acc;
    longint unsigned b;
    int n;
    acc = 64'd1 << 32;
    b = base_in;
    n = n_in;
    while (n != 0) begin
      if ((n & 1) != 0) acc = (acc * b) >> 32;
      b = (b * b) >> 32;
      n = n >> 1;
    end
    return acc;
  endfunction

  // Build (1 - 0.3^(k/D)) / 0.7 in Q0.16
  function automatic curve_t build_curve();
    curve_t tbl;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned v;
    longint unsigned f;
    lo = 0;
    hi = (64'd1 << 32) - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (q32_pow(mid, CURVE_DEPTH) <= 64'd1288490189) lo = mid;
      else hi = mid - 1;
    end
    v = 64'd1 << 32;
    tbl[0] = '0;
    for (int k = 1; k <= CURVE_DEPTH; k++) begin
      v = (v * lo) >> 32;
      f = ((((64'd1 << 32) - v) * 10 / 7) + 32768) >> 16;
      tbl[k] = (f > 65536) ? FULL_LEVEL : LEVEL_W'(f);
    end
    tbl[CURVE_DEPTH] = FULL_LEVEL;
    return tbl;
  endfunction

endpackage

[sv/adsr_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adsr_div - bit-serial phase increment divider
// Computes floor(2^(PHASE_FRAC_BITS+16) / den) one quotient bit per cycle
// with a single compare and subtract. Valid for den >= 2^16.
// ---------------------------------------------------------------------------
module adsr_div #(
  parameter int PHASE_FRAC_BITS = adsr_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [adsr_pkg::DEN_W-1:0]          den,
  output logic                                done,
  output logic [PHASE_FRAC_BITS:0]            quot
);
  import adsr_pkg::*;

  localparam int Q_W   = PHASE_FRAC_BITS + 1;
  localparam int CNT_W = $clog2(Q_W + 1);
  localparam int REM_W = DEN_W + 1;

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] shifted;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             take;

  // Shift in a zero numerator bit, compare against the divisor
  assign shifted = {rem[REM_W-2:0], 1'b0};
  assign take    = shifted >= {1'b0, den};

  // Run one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
        rem  <= REM_W'(1) << 15;
        quot <= '0;
      end else if (busy) begin
        rem  <= take ? (shifted - {1'b0, den}) : shifted;
        quot <= {quot[Q_W-2:0], take};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/adsr_envelope_generator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adsr_envelope_generator - ADSR envelope, one audio sample per word
// Saturates the modulated segment times, advances the phase by a divided
// increment, reads the exponential curve and blends start and target levels.
// ---------------------------------------------------------------------------
// Channel  Dir  Word contents
// s_       in   tdata: attack_offset, decay_offset, sustain_offset,
//                      release_offset (17b signed each); tuser: gate
// m_       out  tdata: level (17b); tuser: active, stage_now
// cfg_     in   cfg_index selects register, cfg_data carries the value
//
// Each word's phase increment is formed by the bit-serial divider; a
// whole-step increment skips the divider.
// s_tready is high only while the sequencer is idle; a finished word waits
// in the output register, and the next input word is taken meanwhile.
// Reset (rst, synchronous) restores register defaults and envelope state.
// Configuration writes are always accepted.
// ---------------------------------------------------------------------------
module adsr_envelope_generator #(
  parameter int PHASE_FRAC_BITS = adsr_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [71:0]                        s_tdata,  // att, dec, sus, rel offsets
  input  logic [0:0]                         s_tuser,  // gate
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [23:0]                        m_tdata,  // level
  output logic [2:0]                         m_tuser,  // active, stage_now
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adsr_pkg::RATE_W-1:0]        cfg_data
);
  import adsr_pkg::*;

  localparam int PHASE_W = PHASE_FRAC_BITS + 1;
  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;
  localparam curve_t CURVE = build_curve();

  // Configuration registers
  logic [TIME_W-1:0]  attack_time;
  logic [TIME_W-1:0]  decay_time;
  logic [LEVEL_W-1:0] sustain_level;
  logic [TIME_W-1:0]  release_time;
  logic [SCALE_W-1:0] time_scale;
  logic [RATE_W-1:0]  sample_rate;

  // Envelope state
  stage_t             stage;
  logic [PHASE_W-1:0] phase;
  logic [LEVEL_W-1:0] start_level;
  logic [LEVEL_W-1:0] target_level;
  logic               running;

  // Per-word working registers
  state_t             state, state_next;
  logic [TIME_W-1:0]  a_sum, d_sum, r_sum;
  logic [LEVEL_W-1:0] s_sum;
  logic               gate;
  logic [PROD_W-1:0]  prod;
  logic [DEN_W-1:0]   den;
  logic [PHASE_W-1:0] inc;
  logic [LEVEL_W-1:0] rom_a, rom_b;
  logic [LEVEL_W-1:0] curve_c;
  logic [2*LEVEL_W-1:0] acc;
  logic [LEVEL_W-1:0] level_q;

  // Combinational helpers
  logic               in_accept;
  logic               den_small;
  logic               div_start;
  logic               div_done;
  logic [PHASE_W-1:0] div_quot;
  logic               out_load;
  logic [TIME_W-1:0]  t_sel;
  logic [PHASE_W:0]   phase_sum;
  logic [CURVE_AW-1:0] idx;
  logic [CURVE_AW-1:0] idx_hi;
  logic [PHASE_FRAC_BITS-1:0] frac;
  logic [LEVEL_W+PHASE_FRAC_BITS-1:0] interp;
  logic [2*LEVEL_W-1:0] blend;
  logic [LEVEL_W-1:0] level_w;

  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign den_small = den < (DEN_W'(1) << 16);

  // Segment time of the current stage
  always_comb begin
    case (stage)
      STG_ATTACK:  t_sel = a_sum;
      STG_DECAY:   t_sel = d_sum;
      STG_SUSTAIN: t_sel = '0;
      default:     t_sel = r_sum;
    endcase
  end

  // Curve table address and interpolation fraction
  assign phase_sum = {1'b0, phase} + {1'b0, inc};
  assign idx       = phase[PHASE_FRAC_BITS -: CURVE_AW];
  assign idx_hi    = (idx >= CURVE_AW'(CURVE_DEPTH)) ? CURVE_AW'(CURVE_DEPTH)
                                                     : idx + 1'b1;
  assign frac      = {phase[PHASE_FRAC_BITS-CURVE_LOG2-1:0], CURVE_LOG2'(0)};
  assign interp    = (rom_b - rom_a) * frac;
  assign blend     = acc + target_level * curve_c + (2*LEVEL_W)'(32768);
  assign level_w   = blend[16 +: LEVEL_W];

  adsr_div #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Next state of the sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_accept) state_next = ST_PROD;
      ST_PROD:   state_next = ST_DEN;
      ST_DEN:    state_next = ST_CHK;
      ST_CHK:    state_next = den_small ? ST_PHASE : ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_PHASE;
      ST_PHASE:  state_next = ST_RD_A;
      ST_RD_A:   state_next = ST_RD_B;
      ST_RD_B:   state_next = ST_INTERP;
      ST_INTERP: state_next = ST_MUL0;
      ST_MUL0:   state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_OUT;
      ST_OUT:    if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = (state == ST_IDLE);
    div_start = (state == ST_CHK) && !den_small;
    out_load  = (state == ST_OUT) && (!m_tvalid || m_tready);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_time   <= TIME_W'(66);
      decay_time    <= TIME_W'(6554);
      sustain_level <= LEVEL_W'(46334);
      release_time  <= TIME_W'(13107);
      time_scale    <= SCALE_W'(1);
      sample_rate   <= RATE_W'(48000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ATTACK:  attack_time   <= cfg_data[TIME_W-1:0];
        CFG_DECAY:   decay_time    <= cfg_data[TIME_W-1:0];
        CFG_SUSTAIN: sustain_level <= cfg_data[LEVEL_W-1:0];
        CFG_RELEASE: release_time  <= cfg_data[TIME_W-1:0];
        CFG_SCALE:   time_scale    <= cfg_data[SCALE_W-1:0];
        CFG_RATE:    sample_rate   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, envelope state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stage        <= STG_ATTACK;
      phase        <= '0;
      start_level  <= '0;
      target_level <= FULL_LEVEL;
      running      <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            a_sum <= TIME_W'(sat_sum({1'b0, attack_time},  s_tdata[16:0],  {1'b0, TIME_MAX}));
            d_sum <= TIME_W'(sat_sum({1'b0, decay_time},   s_tdata[33:17], {1'b0, TIME_MAX}));
            s_sum <= sat_sum(sustain_level, s_tdata[50:34], FULL_LEVEL);
            r_sum <= TIME_W'(sat_sum({1'b0, release_time}, s_tdata[67:51], {1'b0, TIME_MAX}));
            gate  <= s_tuser[0];
          end
        end
        ST_PROD: begin
          prod <= t_sel * time_scale;
          case (stage)
            STG_ATTACK: begin
              start_level  <= '0;
              target_level <= (d_sum != '0) ? FULL_LEVEL : s_sum;
            end
            STG_DECAY: target_level <= s_sum;
            STG_SUSTAIN: begin
              start_level  <= s_sum;
              target_level <= s_sum;
            end
            default: ;
          endcase
        end
        ST_DEN: den <= prod * sample_rate;
        ST_CHK: if (den_small) inc <= PHASE_ONE;
        ST_DIV: if (div_done) inc <= (div_quot > PHASE_ONE) ? PHASE_ONE : div_quot;
        ST_PHASE: begin
          if (phase_sum >= {1'b0, PHASE_ONE}) begin
            case (stage)
              STG_ATTACK: begin
                stage       <= STG_DECAY;
                start_level <= target_level;
                phase       <= '0;
              end
              STG_DECAY: begin
                stage <= STG_SUSTAIN;
                phase <= PHASE_ONE;
              end
              STG_SUSTAIN: phase <= '0;
              default: begin
                running <= 1'b0;
                phase   <= PHASE_ONE;
              end
            endcase
          end else begin
            phase <= phase_sum[PHASE_W-1:0];
          end
        end
        ST_RD_A: rom_a <= CURVE[idx];
        ST_RD_B: rom_b <= CURVE[idx_hi];
        ST_INTERP: begin
          if (phase >= PHASE_ONE) curve_c <= FULL_LEVEL;
          else curve_c <= rom_a + interp[PHASE_FRAC_BITS +: LEVEL_W];
        end
        ST_MUL0: acc <= start_level * (FULL_LEVEL - curve_c);
        ST_MUL1: begin
          level_q <= level_w;
          // Apply the gate after the output is formed
          if (gate && (!running || stage == STG_RELEASE)) begin
            stage   <= STG_ATTACK;
            phase   <= '0;
            running <= 1'b1;
          end else if (!gate && stage != STG_RELEASE) begin
            stage        <= STG_RELEASE;
            start_level  <= level_w;
            target_level <= '0;
            phase        <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {7'd0, level_q};
      m_tuser  <= {stage, running};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // A word with the envelope finished must report the release stage
  a_done_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tuser[2:1] == STG_RELEASE)
    else $error("inactive envelope outside release");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[LEVEL_W-1:0] <= FULL_LEVEL)
    else $error("level above full scale");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PHASE_ONE)
    else $error("phase above one");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside its wait state");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule
